@@ design/pool_occupancy_watermark_monitor_defines.svh @@
// Assertion macros shared by the pool monitor RTL
`ifndef POOL_OCCUPANCY_WATERMARK_MONITOR_DEFINES_SVH
`define POOL_OCCUPANCY_WATERMARK_MONITOR_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset
`define POMON_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define POMON_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pomon_pkg.sv @@
package pomon_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int SPACE_BITS_DEF = 40;
    localparam int SIZE_BITS_DEF  = 32;

    localparam int ID_W       = 32;
    localparam int MAXB_W     = 16;
    localparam int SPWARN_W   = 40;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;

    // register indexes (byte address / 8)
    localparam logic [1:0] REG_MAX_BLOCKS  = 2'd0;
    localparam logic [1:0] REG_BLOCK_WARN  = 2'd1;
    localparam logic [1:0] REG_SPACE_WARN  = 2'd2;
    localparam logic [1:0] REG_WARN_EN     = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam logic [2:0] BCHG_NONE       = 3'd0;
    localparam logic [2:0] BCHG_NONE_USER  = 3'd1;
    localparam logic [2:0] BCHG_USER_LIMIT = 3'd2;
    localparam logic [2:0] BCHG_LIMIT_USER = 3'd3;
    localparam logic [2:0] BCHG_USER_NONE  = 3'd4;

    localparam logic [1:0] SCHG_NONE      = 2'd0;
    localparam logic [1:0] SCHG_NONE_USER = 2'd1;
    localparam logic [1:0] SCHG_USER_NONE = 2'd2;

    typedef enum logic [1:0] {
        LVL_NONE  = 2'd0,
        LVL_USER  = 2'd1,
        LVL_LIMIT = 2'd2
    } lvl_t;

    // floor(y / 10) for y < 2^20 and floor(y / 3) for y < 2^17 by reciprocal
    localparam logic [20:0] DIV10_MUL   = 21'd1677722;
    localparam int          DIV10_SHIFT = 24;
    localparam logic [17:0] DIV3_MUL    = 18'd174763;
    localparam int          DIV3_SHIFT  = 19;

    localparam longint RESET_MAX_BLOCKS = 1024;
    localparam longint RESET_BLOCK_WARN = 768;
    localparam longint RESET_SPACE_WARN = 1048576;

    typedef struct packed {
        logic [MAXB_W-1:0]   max_blocks;
        logic [MAXB_W-1:0]   block_warn;
        logic [SPWARN_W-1:0] space_warn;
        logic                warn_en;
        logic [MAXB_W-1:0]   limit_rise;   // max_blocks * 9 / 10
        logic [MAXB_W-1:0]   limit_fall;   // max_blocks * 2 / 3
        logic [MAXB_W-1:0]   block_fall;   // block_warn * 3 / 4
        logic [SPWARN_W-1:0] space_fall;   // space_warn * 3 / 4
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        max_blocks: MAXB_W'(RESET_MAX_BLOCKS),
        block_warn: MAXB_W'(RESET_BLOCK_WARN),
        space_warn: SPWARN_W'(RESET_SPACE_WARN),
        warn_en:    1'b1,
        limit_rise: MAXB_W'(RESET_MAX_BLOCKS * 9 / 10),
        limit_fall: MAXB_W'(RESET_MAX_BLOCKS * 2 / 3),
        block_fall: MAXB_W'(RESET_BLOCK_WARN * 3 / 4),
        space_fall: SPWARN_W'(RESET_SPACE_WARN * 3 / 4)
    };

endpackage

@@ design/pomon_regs.sv @@
module pomon_regs
    import pomon_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic [1:0]            reg_idx;
    logic                  wr_en;
    logic [MAXB_W-1:0]     wr_max;
    logic [MAXB_W-1:0]     wr_warn;
    logic [SPWARN_W-1:0]   wr_space;
    logic [MAXB_W+3:0]     max_x9;
    logic [MAXB_W+24:0]    rise_prod;
    logic [MAXB_W:0]       max_x2;
    logic [MAXB_W+18:0]    fall_prod;

    // floor(v * 3 / 4) without growing the word
    function automatic logic [SPWARN_W-1:0] three_quarters(input logic [SPWARN_W-1:0] v);
        logic [SPWARN_W-1:0] q;
        logic [3:0]          r3;
        q  = v >> 2;
        r3 = 4'(v[1:0]) * 4'd3;
        return (q + (q << 1)) + SPWARN_W'(r3 >> 2);
    endfunction

    assign reg_idx  = paddr[CFG_ADDR_W-1:3];
    assign wr_en    = psel && penable && pwrite;
    assign wr_max   = pwdata[MAXB_W-1:0];
    assign wr_warn  = pwdata[MAXB_W-1:0];
    assign wr_space = pwdata[SPWARN_W-1:0];

    // derive the alarm thresholds once, when the register is written
    assign max_x9    = {wr_max, 3'b000} + (MAXB_W+4)'(wr_max);
    assign rise_prod = (MAXB_W+25)'(max_x9) * (MAXB_W+25)'(DIV10_MUL);
    assign max_x2    = {wr_max, 1'b0};
    assign fall_prod = (MAXB_W+19)'(max_x2) * (MAXB_W+19)'(DIV3_MUL);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_MAX_BLOCKS:
                begin
                    cfg_next.max_blocks = wr_max;
                    cfg_next.limit_rise = rise_prod[DIV10_SHIFT +: MAXB_W];
                    cfg_next.limit_fall = fall_prod[DIV3_SHIFT +: MAXB_W];
                end
                REG_BLOCK_WARN:
                begin
                    cfg_next.block_warn = wr_warn;
                    cfg_next.block_fall = MAXB_W'(three_quarters(SPWARN_W'(wr_warn)));
                end
                REG_SPACE_WARN:
                begin
                    cfg_next.space_warn = wr_space;
                    cfg_next.space_fall = three_quarters(wr_space);
                end
                REG_WARN_EN:
                begin
                    cfg_next.warn_en = pwdata[0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MAX_BLOCKS: prdata = CFG_DATA_W'(cfg_reg.max_blocks);
            REG_BLOCK_WARN: prdata = CFG_DATA_W'(cfg_reg.block_warn);
            REG_SPACE_WARN: prdata = CFG_DATA_W'(cfg_reg.space_warn);
            REG_WARN_EN:    prdata = CFG_DATA_W'(cfg_reg.warn_en);
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ design/pool_occupancy_watermark_monitor.sv @@
// Block pool occupancy monitor with hysteresis watermark alarms.
// Input stream: one transfer per request; s_tuser is the request kind
// (0 allocate, 1 free), s_tdata carries the block's byte size.
// Output stream: one transfer per request with status, the allocated block
// id, the block count and byte total after the request, the alarm changes
// and the alarm levels now.
// The request is evaluated against the held counters in a single pass and
// lands in the result register. Throughput is one request per cycle, set by
// that one result register: s_tready is high when the result register is
// empty or being drained in the same cycle.
// When the receiver stalls, the result holds and input is refused until it
// is taken; nothing is dropped.
// The APB port sets max_blocks (0x00), block_warn_level (0x08),
// space_warn_level (0x10) and warnings_enabled (0x18); alarm thresholds are
// derived when a register is written. Write only while no request is open.
// Reset clears the counters, the next block id and both alarms to none,
// and loads the register defaults.
`include "pool_occupancy_watermark_monitor_defines.svh"

module pool_occupancy_watermark_monitor
    import pomon_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int SPACE_BITS = SPACE_BITS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF,
    localparam int IN_W      = ((SIZE_BITS + 7) / 8) * 8,
    localparam int OUT_RAW   = 2 + ID_W + COUNT_BITS + SPACE_BITS + 3 + 2 + 2 + 1,
    localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // block_size
    input  logic                  s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status, block_id, block_count, space_used, block_change, space_change,
    // block_level, space_level
    output logic [OUT_W-1:0]      m_tdata
);

    localparam int CMP_W  = (COUNT_BITS > MAXB_W) ? COUNT_BITS : MAXB_W;
    localparam int SUM_W  = ((SPACE_BITS > SIZE_BITS) ? SPACE_BITS : SIZE_BITS) + 1;
    localparam int SCMP_W = (SPACE_BITS > SPWARN_W) ? SPACE_BITS : SPWARN_W;

    cfg_t cfg;

    logic [COUNT_BITS-1:0] held_blocks_reg, held_blocks_next;
    logic [SPACE_BITS-1:0] held_bytes_reg, held_bytes_next;
    logic [ID_W-1:0]       next_id_reg, next_id_next;
    lvl_t                  block_lvl_reg, block_lvl_next;
    logic                  space_lvl_reg, space_lvl_next;

    logic                  m_tvalid_reg;
    logic [1:0]            status_reg, status_next;
    logic [ID_W-1:0]       id_out_reg, id_out_next;
    logic [COUNT_BITS-1:0] count_out_reg;
    logic [SPACE_BITS-1:0] space_out_reg;
    logic [2:0]            bchg_reg, bchg_next;
    logic [1:0]            schg_reg, schg_next;
    lvl_t                  blvl_out_reg;
    logic                  slvl_out_reg;

    logic                  accept;
    logic                  freeing;
    logic [SIZE_BITS-1:0]  size;
    logic                  cnt_full;
    logic [SUM_W-1:0]      sum;
    logic                  sum_sat;
    logic                  bytes_short;
    logic                  evaluate;
    logic [CMP_W-1:0]      n_ext;
    logic [SCMP_W-1:0]     bytes_ext;

    pomon_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready   = 1'b1;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign freeing  = s_tuser;
    assign size     = s_tdata[SIZE_BITS-1:0];

    // refuse at max_blocks or when the counter itself has run out of range
    assign cnt_full    = (held_blocks_reg == {COUNT_BITS{1'b1}}) ||
                         (CMP_W'(held_blocks_reg) >= CMP_W'(cfg.max_blocks));
    assign sum         = SUM_W'(held_bytes_reg) + SUM_W'(size);
    assign sum_sat     = sum > SUM_W'({SPACE_BITS{1'b1}});
    assign bytes_short = SUM_W'(held_bytes_reg) < SUM_W'(size);

    always_comb
    begin
        held_blocks_next = held_blocks_reg;
        held_bytes_next  = held_bytes_reg;
        next_id_next     = next_id_reg;
        status_next      = ST_OK;
        id_out_next      = '0;
        evaluate         = 1'b1;
        if (!freeing)
        begin
            if (cnt_full)
            begin
                status_next = ST_FULL;
                evaluate    = 1'b0;
            end
            else
            begin
                id_out_next      = next_id_reg;
                next_id_next     = next_id_reg + 1'b1;
                held_blocks_next = held_blocks_reg + 1'b1;
                held_bytes_next  = sum_sat ? {SPACE_BITS{1'b1}} : sum[SPACE_BITS-1:0];
            end
        end
        else
        begin
            // saturate each counter at zero on its own
            if (held_blocks_reg == '0)
            begin
                status_next = ST_UNDERFLOW;
            end
            else
            begin
                held_blocks_next = held_blocks_reg - 1'b1;
            end
            if (bytes_short)
            begin
                held_bytes_next = '0;
                status_next     = ST_UNDERFLOW;
            end
            else
            begin
                held_bytes_next = SPACE_BITS'(SUM_W'(held_bytes_reg) - SUM_W'(size));
            end
        end
    end

    assign n_ext     = CMP_W'(held_blocks_next);
    assign bytes_ext = SCMP_W'(held_bytes_next);

    // hysteresis: at most one step per request, direction set by the request
    always_comb
    begin
        block_lvl_next = block_lvl_reg;
        space_lvl_next = space_lvl_reg;
        bchg_next      = BCHG_NONE;
        schg_next      = SCHG_NONE;
        if (evaluate && cfg.warn_en)
        begin
            if (freeing)
            begin
                if (block_lvl_reg == LVL_LIMIT && n_ext < CMP_W'(cfg.limit_fall))
                begin
                    block_lvl_next = LVL_USER;
                    bchg_next      = BCHG_LIMIT_USER;
                end
                else if (block_lvl_reg == LVL_USER && n_ext < CMP_W'(cfg.block_fall))
                begin
                    block_lvl_next = LVL_NONE;
                    bchg_next      = BCHG_USER_NONE;
                end
                if (space_lvl_reg && bytes_ext < SCMP_W'(cfg.space_fall))
                begin
                    space_lvl_next = 1'b0;
                    schg_next      = SCHG_USER_NONE;
                end
            end
            else
            begin
                if (block_lvl_reg == LVL_NONE && n_ext >= CMP_W'(cfg.block_warn))
                begin
                    block_lvl_next = LVL_USER;
                    bchg_next      = BCHG_NONE_USER;
                end
                else if (block_lvl_reg == LVL_USER && n_ext >= CMP_W'(cfg.limit_rise))
                begin
                    block_lvl_next = LVL_LIMIT;
                    bchg_next      = BCHG_USER_LIMIT;
                end
                if (!space_lvl_reg && bytes_ext >= SCMP_W'(cfg.space_warn))
                begin
                    space_lvl_next = 1'b1;
                    schg_next      = SCHG_NONE_USER;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_blocks_reg <= '0;
            held_bytes_reg  <= '0;
            next_id_reg     <= '0;
            block_lvl_reg   <= LVL_NONE;
            space_lvl_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                held_blocks_reg <= held_blocks_next;
                held_bytes_reg  <= held_bytes_next;
                next_id_reg     <= next_id_next;
                block_lvl_reg   <= block_lvl_next;
                space_lvl_reg   <= space_lvl_next;
                m_tvalid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload; load only on a new transfer so a stall holds it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            id_out_reg    <= id_out_next;
            count_out_reg <= held_blocks_next;
            space_out_reg <= held_bytes_next;
            bchg_reg      <= bchg_next;
            schg_reg      <= schg_next;
            blvl_out_reg  <= block_lvl_next;
            slvl_out_reg  <= space_lvl_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({slvl_out_reg, blvl_out_reg, schg_reg, bchg_reg,
                              space_out_reg, count_out_reg, id_out_reg, status_reg});

    `POMON_ASSERT_NEXT(a_full_holds_state,
        accept && !freeing && cnt_full,
        $stable(held_blocks_reg) && $stable(held_bytes_reg) && $stable(next_id_reg),
        "refused allocate changed the pool state")
    `POMON_ASSERT_NEXT(a_block_alarm_one_step,
        block_lvl_reg == LVL_NONE,
        block_lvl_reg != LVL_LIMIT,
        "block alarm jumped from none to limit")
    `POMON_ASSERT_NEXT(a_state_idle_hold,
        !accept,
        $stable(held_blocks_reg) && $stable(held_bytes_reg) && $stable(block_lvl_reg),
        "pool state changed without a request transfer")

endmodule
